// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the profile sampler sequencer (plps_ctrl).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/plps_pkg.sv
// ----------------------------------------------------------------------------
// plps_pkg
// Shared types and constants of the piecewise linear profile sampler.
// ----------------------------------------------------------------------------
package plps_pkg;

  localparam int NUM_VALUES  = 8;
  localparam int ROW_IDX_W   = 6;
  localparam int RADIUS_W    = 32;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int LANE_W      = 3;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FIRST, S_LAST, S_CHK, S_PRIME, S_SCAN,
    S_VA, S_VB, S_VC, S_DIV, S_MUL, S_DONE
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                load_wr;
    logic                rad_rd;
    logic                first_latch;
    logic                left_latch;
    logic                div_init;
    logic                val_rd;
    logic                a_latch;
    logic                b_latch;
    logic                div_step;
    logic                mul_en;
    logic [LANE_W-1:0]   mul_k;
    logic                res_en;
    logic [LANE_W-1:0]   res_k;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic lt_first;
    logic gt_last;
    logic in_seg;
  } stat_t;

endpackage

// File: hdl/plps_datapath.sv
// ----------------------------------------------------------------------------
// plps_datapath
// Breakpoint memories, segment compare, serial weight divider, lane multiply
// and the output word register.
// ----------------------------------------------------------------------------
module plps_datapath #(
  parameter int MAX_ROWS    = plps_pkg::MAX_ROWS_DEF,
  parameter int VALUE_WIDTH = plps_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_BITS = plps_pkg::WEIGHT_BITS_DEF,
  parameter int AW          = $clog2(MAX_ROWS)
) (
  input  logic                                       clk,
  input  logic [plps_pkg::ROW_IDX_W-1:0]             in_row,
  input  logic [plps_pkg::RADIUS_W-1:0]              in_radius,
  input  logic [plps_pkg::NUM_VALUES*VALUE_WIDTH-1:0] in_vals,
  input  plps_pkg::cmd_t                             cmd,
  input  logic [AW-1:0]                              row_addr,
  output plps_pkg::stat_t                            stat,
  output logic [plps_pkg::STATUS_W-1:0]              out_status,
  output logic [plps_pkg::RADIUS_W-1:0]              out_radius,
  output logic [plps_pkg::NUM_VALUES*VALUE_WIDTH-1:0] out_vals
);

  localparam int NV = plps_pkg::NUM_VALUES;
  localparam int VW = VALUE_WIDTH;
  localparam int WB = WEIGHT_BITS;
  localparam int RW = plps_pkg::RADIUS_W;
  localparam int PW = VW + WB + 3;

  logic [RW-1:0]        rad_mem [MAX_ROWS];
  logic [NV*VW-1:0]     val_mem [MAX_ROWS];

  logic [plps_pkg::ROW_IDX_W-1:0] row_r;
  logic [RW-1:0]        radius_r;
  logic [NV*VW-1:0]     vals_r;
  logic [RW-1:0]        rad_q_r;
  logic [NV*VW-1:0]     val_q_r;
  logic [RW-1:0]        first_r;
  logic [RW-1:0]        left_r;
  logic [RW:0]          rem_r;
  logic [RW-1:0]        span_r;
  logic [WB:0]          q_r;
  logic signed [VW-1:0] a_r    [NV];
  logic signed [VW:0]   diff_r [NV];
  logic signed [PW-1:0] prod_r;
  logic [VW-1:0]        res_r  [NV];

  logic                 rem_ge;
  logic [RW:0]          rem_sub;
  logic [WB:0]          wt;

  assign rem_ge  = rem_r >= {1'b0, span_r};
  assign rem_sub = rem_ge ? (rem_r - {1'b0, span_r}) : rem_r;
  assign wt      = (span_r == '0) ? '0 : q_r;

  assign stat.lt_first = radius_r < first_r;
  assign stat.gt_last  = radius_r > rad_q_r;
  assign stat.in_seg   = (radius_r >= left_r) && (radius_r <= rad_q_r);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr && (int'(row_r) < MAX_ROWS)) begin
      rad_mem[AW'(row_r)] <= radius_r;
      val_mem[AW'(row_r)] <= vals_r;
    end
    if (cmd.rad_rd) begin
      rad_q_r <= rad_mem[row_addr];
    end
    if (cmd.val_rd) begin
      val_q_r <= val_mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r    <= in_row;
      radius_r <= in_radius;
      vals_r   <= in_vals;
    end
    if (cmd.first_latch) begin
      first_r <= rad_q_r;
    end
    if (cmd.left_latch) begin
      left_r <= rad_q_r;
    end
    // restoring divide, one quotient bit per step
    if (cmd.div_init) begin
      rem_r  <= {1'b0, radius_r - left_r};
      span_r <= rad_q_r - left_r;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[RW-1:0], 1'b0};
      q_r   <= {q_r[WB-1:0], rem_ge};
    end
    if (cmd.mul_en) begin
      prod_r <= diff_r[cmd.mul_k] * $signed({1'b0, wt});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NV; k++) begin
      if (cmd.a_latch) begin
        a_r[k] <= val_q_r[k*VW +: VW];
      end
      if (cmd.b_latch) begin
        diff_r[k] <= {val_q_r[k*VW+VW-1], val_q_r[k*VW +: VW]} - {a_r[k][VW-1], a_r[k]};
      end
      if (cmd.capture) begin
        res_r[k] <= '0;
      end else if (cmd.res_en && (int'(cmd.res_k) == k)) begin
        res_r[k] <= a_r[k] + prod_r[WB +: VW];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.status;
      out_radius <= radius_r;
      for (int k = 0; k < NV; k++) begin
        out_vals[k*VW +: VW] <= res_r[k];
      end
    end
  end

endmodule

// File: hdl/plps_ctrl.sv
// ----------------------------------------------------------------------------
// plps_ctrl
// Sequencer: row count register, table scan, divide and multiply steps,
// output word valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plps_ctrl #(
  parameter int MAX_ROWS    = plps_pkg::MAX_ROWS_DEF,
  parameter int WEIGHT_BITS = plps_pkg::WEIGHT_BITS_DEF,
  parameter int AW          = $clog2(MAX_ROWS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_req,
  output logic                          in_tready,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  input  logic                          cfg_wr_en,
  input  logic [plps_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  plps_pkg::stat_t               stat,
  output plps_pkg::cmd_t                cmd,
  output logic [AW-1:0]                 row_addr
);

  localparam int IW = $clog2(MAX_ROWS + 1);
  localparam int SW = $clog2(WEIGHT_BITS + 1);
  localparam int KW = plps_pkg::LANE_W + 1;

  plps_pkg::state_t state_r, state_nxt;
  logic [plps_pkg::COUNT_W-1:0]  cnt_r;
  logic [IW-1:0]                 count_s;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [SW-1:0]                 step_r, step_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic [plps_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          out_valid_r;
  logic                          in_fire;
  logic                          slot_free;

  assign count_s   = (int'(cnt_r) > MAX_ROWS) ? IW'(MAX_ROWS) : IW'(cnt_r);
  assign in_tready = (state_r == plps_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plps_pkg::S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      k_r         <= '0;
      status_r    <= plps_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      step_r   <= step_nxt;
      k_r      <= k_nxt;
      status_r <= status_nxt;
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plps_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_req == plps_pkg::REQ_LOAD) begin
            state_nxt = plps_pkg::S_LOAD;
          end else if (count_s == '0) begin
            state_nxt = plps_pkg::S_DONE;
          end else begin
            state_nxt = plps_pkg::S_FIRST;
          end
        end
      end
      plps_pkg::S_LOAD:  state_nxt = plps_pkg::S_DONE;
      plps_pkg::S_FIRST: state_nxt = plps_pkg::S_LAST;
      plps_pkg::S_LAST:  state_nxt = plps_pkg::S_CHK;
      plps_pkg::S_CHK: begin
        if (stat.lt_first || stat.gt_last || (count_s < IW'(2))) begin
          state_nxt = plps_pkg::S_DONE;
        end else begin
          state_nxt = plps_pkg::S_PRIME;
        end
      end
      plps_pkg::S_PRIME: state_nxt = plps_pkg::S_SCAN;
      plps_pkg::S_SCAN: begin
        if (stat.in_seg) begin
          state_nxt = plps_pkg::S_VA;
        end else if (idx_r >= count_s - 1'b1) begin
          state_nxt = plps_pkg::S_DONE;
        end
      end
      plps_pkg::S_VA: state_nxt = plps_pkg::S_VB;
      plps_pkg::S_VB: state_nxt = plps_pkg::S_VC;
      plps_pkg::S_VC: state_nxt = plps_pkg::S_DIV;
      plps_pkg::S_DIV: begin
        if (step_r == SW'(WEIGHT_BITS)) begin
          state_nxt = plps_pkg::S_MUL;
        end
      end
      plps_pkg::S_MUL: begin
        if (k_r == KW'(plps_pkg::NUM_VALUES)) begin
          state_nxt = plps_pkg::S_DONE;
        end
      end
      plps_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = plps_pkg::S_IDLE;
        end
      end
      default: state_nxt = plps_pkg::S_IDLE;
    endcase
  end

  // commands and counters
  always_comb begin
    cmd        = '0;
    cmd.status = status_r;
    row_addr   = '0;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    unique case (state_r)
      plps_pkg::S_IDLE: begin
        cmd.capture = in_fire;
        status_nxt  = (in_req == plps_pkg::REQ_SAMPLE && count_s == '0) ?
                      plps_pkg::ST_EMPTY : plps_pkg::ST_OK;
      end
      plps_pkg::S_LOAD: cmd.load_wr = 1'b1;
      plps_pkg::S_FIRST: cmd.rad_rd = 1'b1;
      plps_pkg::S_LAST: begin
        cmd.first_latch = 1'b1;
        cmd.rad_rd      = 1'b1;
        row_addr        = AW'(count_s - 1'b1);
      end
      plps_pkg::S_CHK: begin
        cmd.rad_rd = 1'b1;
        if (stat.lt_first || stat.gt_last || (count_s < IW'(2))) begin
          status_nxt = plps_pkg::ST_OUTSIDE;
        end
      end
      plps_pkg::S_PRIME: begin
        cmd.left_latch = 1'b1;
        cmd.rad_rd     = 1'b1;
        row_addr       = AW'(1);
        idx_nxt        = IW'(1);
      end
      plps_pkg::S_SCAN: begin
        if (stat.in_seg) begin
          cmd.div_init = 1'b1;
        end else if (idx_r >= count_s - 1'b1) begin
          status_nxt = plps_pkg::ST_OUTSIDE;
        end else begin
          // advance to the next segment
          cmd.left_latch = 1'b1;
          cmd.rad_rd     = 1'b1;
          row_addr       = AW'(idx_r + 1'b1);
          idx_nxt        = idx_r + 1'b1;
        end
      end
      plps_pkg::S_VA: begin
        cmd.val_rd = 1'b1;
        row_addr   = AW'(idx_r - 1'b1);
      end
      plps_pkg::S_VB: begin
        cmd.a_latch = 1'b1;
        cmd.val_rd  = 1'b1;
        row_addr    = AW'(idx_r);
      end
      plps_pkg::S_VC: begin
        cmd.b_latch = 1'b1;
        step_nxt    = '0;
      end
      plps_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        k_nxt        = '0;
      end
      plps_pkg::S_MUL: begin
        cmd.mul_en = (k_r < KW'(plps_pkg::NUM_VALUES));
        cmd.mul_k  = k_r[plps_pkg::LANE_W-1:0];
        cmd.res_en = (k_r != '0);
        cmd.res_k  = plps_pkg::LANE_W'(k_r - 1'b1);
        k_nxt      = k_r + 1'b1;
      end
      plps_pkg::S_DONE: cmd.out_load = slot_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_out_slot, cmd.out_load |-> (!out_valid_r || out_tready), "output word overwritten")
  `ASSERT_NEVER(a_div_mul, cmd.div_step && cmd.mul_en, "divider and multiplier active together")
  `ASSERT_ALWAYS(a_empty, (in_fire && in_req == plps_pkg::REQ_SAMPLE && count_s == '0) |=> (state_r == plps_pkg::S_DONE && status_r == plps_pkg::ST_EMPTY), "empty table not flagged")

endmodule

// File: hdl/piecewise_linear_profile_sampler_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_profile_sampler_unit
// Breakpoint table with linear interpolation of eight profile values.
// ----------------------------------------------------------------------------
//  channel | dir | word contents
//  in_     | in  | tuser: req_type; tdata: row_index, radius, 8 values
//  out_    | out | tuser: status;   tdata: radius, 8 interpolated values
//  cfg_    | in  | wr_data: row_count, written when wr_en is high
//
//  Load word: the row is written to the table, then the result goes out. A
//  new word is taken only once the last result is in the output register.
//  Sample word: end rows read and checked, one-row-per-cycle scan of 1 to
//  MAX_ROWS-1 segments, WEIGHT_BITS+1 step divider, one lane multiply per
//  cycle; empty table: no steps; radius beyond the end rows: checks only.
//  Reset clears control only; a finished word stalls the sequencer only when
//  the next result is ready before that word is taken.
// ----------------------------------------------------------------------------
module piecewise_linear_profile_sampler_unit #(
  parameter int MAX_ROWS    = plps_pkg::MAX_ROWS_DEF,
  parameter int VALUE_WIDTH = plps_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_BITS = plps_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // row_index, radius, density, electron_temp, ion_temp, vel_radial,
  // vel_theta, vel_phi, alpha_energy, rad_scale, zero pad
  input  logic [((plps_pkg::ROW_IDX_W + plps_pkg::RADIUS_W
                  + plps_pkg::NUM_VALUES*VALUE_WIDTH + 7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_radius, out_density, out_electron_temp, out_ion_temp, out_vel_radial,
  // out_vel_theta, out_vel_phi, out_alpha_energy, out_rad_scale, zero pad
  output logic [((plps_pkg::RADIUS_W
                  + plps_pkg::NUM_VALUES*VALUE_WIDTH + 7)/8)*8-1:0] out_tdata,
  // status
  output logic [plps_pkg::STATUS_W-1:0] out_tuser,
  input  logic cfg_wr_en,
  input  logic [plps_pkg::COUNT_W-1:0] cfg_wr_data
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int VALS = plps_pkg::NUM_VALUES * VALUE_WIDTH;
  localparam int OUTW = ((plps_pkg::RADIUS_W + VALS + 7)/8)*8;
  localparam int PADO = OUTW - plps_pkg::RADIUS_W - VALS;
  localparam int VOFF = plps_pkg::ROW_IDX_W + plps_pkg::RADIUS_W;

  plps_pkg::cmd_t  cmd;
  plps_pkg::stat_t stat;
  logic [AW-1:0]   row_addr;
  logic [plps_pkg::RADIUS_W-1:0] res_radius;
  logic [VALS-1:0] res_vals;

  plps_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req      (in_tuser),
    .in_tready   (in_tready),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd),
    .row_addr    (row_addr)
  );

  plps_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS),
    .AW          (AW)
  ) u_dp (
    .clk        (clk),
    .in_row     (in_tdata[plps_pkg::ROW_IDX_W-1:0]),
    .in_radius  (in_tdata[plps_pkg::ROW_IDX_W +: plps_pkg::RADIUS_W]),
    .in_vals    (in_tdata[VOFF +: VALS]),
    .cmd        (cmd),
    .row_addr   (row_addr),
    .stat       (stat),
    .out_status (out_tuser),
    .out_radius (res_radius),
    .out_vals   (res_vals)
  );

  // pack the result word, radius in the low bits
  if (PADO > 0) begin : g_pad
    assign out_tdata = {{PADO{1'b0}}, res_vals, res_radius};
  end else begin : g_nopad
    assign out_tdata = {res_vals, res_radius};
  end

endmodule
